@@ rtl/itoa_pkg.sv @@
package itoa_pkg;

    localparam int NUM_DIGITS = 10;
    localparam int VALUE_W    = 32;
    localparam int CH_W       = 7;
    localparam int DIGIT_W    = 4;
    localparam int IDX_W      = 4;
    localparam int PW_W       = 36;

    localparam logic [CH_W-1:0] CH_MINUS = 7'd45;
    localparam logic [CH_W-1:0] CH_ZERO  = 7'd48;
    localparam logic [CH_W-1:0] CH_NINE  = 7'd57;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_digits;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] rem;
        logic               started;
        logic [IDX_W-1:0]   first;
        t_digits            digits;
    } t_conv;

    // weight of digit position pos, most significant position first
    function automatic logic [PW_W-1:0] pow10(input logic [IDX_W-1:0] pos);
        logic [PW_W-1:0] p;
        begin
            unique case (pos)
                4'd0:    p = 36'd1000000000;
                4'd1:    p = 36'd100000000;
                4'd2:    p = 36'd10000000;
                4'd3:    p = 36'd1000000;
                4'd4:    p = 36'd100000;
                4'd5:    p = 36'd10000;
                4'd6:    p = 36'd1000;
                4'd7:    p = 36'd100;
                4'd8:    p = 36'd10;
                4'd9:    p = 36'd1;
                default: p = '0;
            endcase
            return p;
        end
    endfunction

endpackage

@@ rtl/signed_int_to_decimal_ascii_top.sv @@
// channel  direction  handshake           payload
// input    in         i_valid / o_stall   i_value (32b signed)
// output   out        o_valid / i_stall   o_ch (7b), o_last
//
// Front register takes sign and magnitude, then ten stages each resolve one
// decimal digit (compare against nine multiples of 10^n, subtract).
// The output port moves one character per cycle while i_stall is low; a
// number takes 1 to 11 characters (its text length).
// Reset is synchronous, active low, and empties every stage.
// Stalls back up stage by stage; held items are neither lost nor repeated.
module signed_int_to_decimal_ascii_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [itoa_pkg::VALUE_W-1:0] i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [itoa_pkg::CH_W-1:0]     o_ch,
    output logic                          o_last
);
    import itoa_pkg::*;

    logic                r_f_valid;
    t_conv               r_f_data;
    t_conv               n_f_data;
    logic                w_f_ready;

    logic                w_valid [0:NUM_DIGITS];
    logic                w_ready [0:NUM_DIGITS];
    t_conv               w_data  [0:NUM_DIGITS];

    logic                r_busy;
    logic                r_sneg;
    logic [IDX_W-1:0]    r_sidx;
    t_digits             r_sdig;
    logic                r_valid;
    logic [CH_W-1:0]     r_ch;
    logic                r_last;
    logic                w_adv;
    logic                w_fin;
    logic                w_take;

    // front stage: sign and magnitude
    always_comb begin
        n_f_data         = '0;
        n_f_data.neg     = i_value[VALUE_W-1];
        n_f_data.rem     = i_value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(i_value))
                                              : $unsigned(i_value);
        n_f_data.started = 1'b0;
        n_f_data.first   = IDX_W'(NUM_DIGITS-1);
    end

    assign w_f_ready = !r_f_valid || w_ready[0];
    assign o_stall   = !w_f_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_f_ready) begin
            r_f_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_f_ready && i_valid) begin
            r_f_data <= n_f_data;
        end
    end

    assign w_valid[0] = r_f_valid;
    assign w_data[0]  = r_f_data;

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_digit
        itoa_stage #(
            .POS (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_ready (w_ready[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1]),
            .i_ready (w_ready[g+1])
        );
    end

    // serializer: minus sign, then digits from the first significant one
    assign w_adv  = !r_valid || !i_stall;
    assign w_fin  = r_busy && !r_sneg && (r_sidx == IDX_W'(NUM_DIGITS-1));
    assign w_ready[NUM_DIGITS] = !r_busy || (w_adv && w_fin);
    assign w_take = w_valid[NUM_DIGITS] && w_ready[NUM_DIGITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_sneg  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_valid <= r_busy;
            end
            if (w_take) begin
                r_busy <= 1'b1;
                r_sneg <= w_data[NUM_DIGITS].neg;
            end else if (w_adv && r_busy) begin
                if (r_sneg) begin
                    r_sneg <= 1'b0;
                end else if (w_fin) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_sidx <= w_data[NUM_DIGITS].first;
            r_sdig <= w_data[NUM_DIGITS].digits;
        end else if (w_adv && r_busy && !r_sneg && !w_fin) begin
            r_sidx <= r_sidx + 1'b1;
        end
        if (w_adv && r_busy) begin
            if (r_sneg) begin
                r_ch   <= CH_MINUS;
                r_last <= 1'b0;
            end else begin
                r_ch   <= CH_ZERO + {{(CH_W-DIGIT_W){1'b0}}, r_sdig[r_sidx]};
                r_last <= w_fin;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_ch    = r_ch;
    assign o_last  = r_last;

`ifndef ASSERT_OFF
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ch == CH_MINUS) || (o_ch >= CH_ZERO && o_ch <= CH_NINE))
        else $error("character out of range");

    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_ch != CH_MINUS))
        else $error("minus sign flagged last");

    a_minus_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_ch == CH_MINUS) |=> (o_valid && o_ch != CH_MINUS))
        else $error("minus sign not followed by a digit");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_sidx <= IDX_W'(NUM_DIGITS-1)))
        else $error("digit index out of range");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_f_valid |-> !o_stall)
        else $error("stall with empty front stage");
`endif

endmodule

@@ rtl/itoa_stage.sv @@
module itoa_stage #(
    parameter int POS = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  itoa_pkg::t_conv i_data,
    output logic            o_ready,
    output logic            o_valid,
    output itoa_pkg::t_conv o_data,
    input  logic            i_ready
);
    import itoa_pkg::*;

    localparam logic [PW_W-1:0] P = pow10(IDX_W'(POS));

    logic                r_valid;
    t_conv               r_data;
    t_conv               n_data;
    logic [DIGIT_W-1:0]  w_digit;
    logic [PW_W-1:0]     w_sub;

    // digit = largest k with k*P <= rem; compares are independent
    always_comb begin
        w_digit = '0;
        w_sub   = '0;
        for (int k = 1; k < 10; k++) begin
            if ({{(PW_W-VALUE_W){1'b0}}, i_data.rem} >= PW_W'(k) * P) begin
                w_digit = DIGIT_W'(k);
                w_sub   = PW_W'(k) * P;
            end
        end
        n_data             = i_data;
        n_data.rem         = i_data.rem - w_sub[VALUE_W-1:0];
        n_data.digits[POS] = w_digit;
        if (!i_data.started && (w_digit != '0 || POS == NUM_DIGITS-1)) begin
            n_data.started = 1'b1;
            n_data.first   = IDX_W'(POS);
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
